// File: rtl/mop_pkg.sv
// shared types, constants and fixed-point helpers for the multibrot orbit plotter
package mop_pkg;

  // fixed-point format of z and c
  localparam int FRAC_BITS = 28;
  localparam int PIX_SHIFT = FRAC_BITS + 2;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PIX_A_W   = 48;
  localparam int PIX_IP_W  = PIX_A_W - PIX_SHIFT + 2;

  // escape limit 4.0 in the fixed-point format, widened for the sum of squares
  localparam logic signed [33:0] ESC_LIM = 34'sd1 <<< (FRAC_BITS + 2);

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_MAX_ITER = 2'd0,
    REG_POWER    = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } reg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_PYW,
    S_SQI,
    S_SQR,
    S_CR,
    S_WB,
    S_ESC,
    S_OUT
  } state_e;

  // tag that travels with a product through the multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PX,
    OP_PY,
    OP_SI,
    OP_SR,
    OP_CR
  } mul_op_e;

  typedef struct packed {
    logic               start_req;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
  } in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               last;
    logic               escaped;
    logic [16:0]        iteration_count;
  } out_t;

  // saturate a 34-bit sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // floor shift of a full product by the fraction bits, then saturate
  function automatic logic signed [31:0] qmul(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [31:0]       r;
    s = p >>> FRAC_BITS;
    if (s[PROD_W-1:31] == '0 || s[PROD_W-1:31] == '1) begin
      r = s[31:0];
    end else if (s[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// File: rtl/mop_mult.sv
// shared signed multiplier with a registered product and operation tag
module mop_mult
  import mop_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  input  mul_op_e                  op_i,
  output logic signed [PROD_W-1:0] prod_o,
  output mul_op_e                  op_o
);

  logic signed [PROD_W-1:0] prod_q;
  mul_op_e                  op_q;

  // tag is control, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else begin
      op_q <= op_i;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
  assign op_o   = op_q;

endmodule

// File: rtl/mop_pixel.sv
// screen coordinate mapping: trunc toward zero of size/2 + a/2^(frac+2), saturated
module mop_pixel
  import mop_pkg::*;
(
  input  logic signed [PROD_W-1:0] prod_i,
  input  logic                     neg_i,
  input  logic [12:0]              size_i,
  output logic signed [15:0]       pix_o
);

  logic signed [PIX_A_W-1:0]  a;
  logic signed [PIX_IP_W-1:0] ip;
  logic [PIX_SHIFT-1:0]       r;
  logic                       frac;
  logic                       ge_half;

  always_comb begin
    // scaled coordinate, negated for the y axis
    a       = neg_i ? -prod_i[PIX_A_W-1:0] : prod_i[PIX_A_W-1:0];
    r       = a[PIX_SHIFT-1:0];
    ge_half = r[PIX_SHIFT-1];
    ip      = PIX_IP_W'($signed(a[PIX_A_W-1:PIX_SHIFT])) + PIX_IP_W'(size_i[12:1]);
    // odd sizes carry a half pixel offset
    if (size_i[0]) begin
      ip   = ip + PIX_IP_W'(ge_half);
      frac = (r != {1'b1, {(PIX_SHIFT-1){1'b0}}});
    end else begin
      frac = (r != '0);
    end
    // floor to trunc for negative values
    if (ip[PIX_IP_W-1] && frac) begin
      ip = ip + PIX_IP_W'(1);
    end
    // saturate to 16 bits
    if (ip > PIX_IP_W'(32767)) begin
      pix_o = 16'sh7fff;
    end else if (ip < -PIX_IP_W'(32768)) begin
      pix_o = 16'sh8000;
    end else begin
      pix_o = ip[15:0];
    end
  end

endmodule

// File: rtl/multibrot_orbit_plotter.sv
// top level: sequencer, orbit state and result register of the orbit plotter
//
// Input channel in_valid_i / in_stall_o carries one beat per orbit step:
// start_req=1 loads c and sets z=c, start_req=0 advances the running orbit.
// Every accepted beat yields exactly one result beat on out_valid_o /
// out_stall_i. A beat that arrives with no orbit running gives an all-zero
// result with valid_res=0, going from idle straight to the hand-off state.
// An orbit step sends all products one at a time through the single registered
// multiplier: two for the pixel mapping, then per complex squaring three
// products plus a write-back state (power=0: one write-back state in their
// place), followed by an escape/update state and a state to hand off the
// result. The input takes the next beat once the sequencer is back in idle.
// in_stall_o is high while a step is in progress; the next beat is taken
// while the previous result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// sequencer waits in its hand-off state until that register frees up.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered
// and belong between steps. Reset clears the orbit (idle) and loads the
// defaults: 255 iterations, power 1, a 640 x 480 screen.
module multibrot_orbit_plotter
  import mop_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  reg_idx_e    cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] max_iter_q;
  logic [3:0]  power_q;
  logic [12:0] width_q, height_q;

  // orbit state
  logic signed [31:0] z_re_q, z_im_q, pt_re_q, pt_im_q, sq_re_q, sq_im_q;
  logic signed [15:0] px_q, py_q;
  logic [16:0]        step_q;
  logic               running_q;
  logic [3:0]         e_q;
  out_t               res_q;

  // output register
  logic out_valid_q;
  out_t out_q;

  // multiplier interface
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  mul_op_e                  mul_op;
  logic signed [PROD_W-1:0] prod;
  mul_op_e                  prod_op;
  logic signed [15:0]       pix;
  logic [12:0]              pix_size;

  logic in_acc, out_free;
  logic signed [33:0] sq_sum;
  logic               esc;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign sq_sum   = 34'(sq_re_q) + 34'(sq_im_q);
  assign esc      = sq_sum > ESC_LIM;

  mop_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .op_i   (mul_op),
    .prod_o (prod),
    .op_o   (prod_op)
  );

  assign pix_size = (prod_op == OP_PY) ? height_q : width_q;

  mop_pixel u_pixel (
    .prod_i (prod),
    .neg_i  (prod_op == OP_PY),
    .size_i (pix_size),
    .pix_o  (pix)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.start_req || running_q) ? S_MX : S_OUT;
        end
      end
      S_MX:  state_d = S_MY;
      S_MY:  state_d = (power_q == '0) ? S_PYW : S_SQI;
      S_PYW: state_d = S_ESC;
      S_SQI: state_d = S_SQR;
      S_SQR: state_d = S_CR;
      S_CR:  state_d = S_WB;
      S_WB:  state_d = (e_q > 4'd1) ? S_SQI : S_ESC;
      S_ESC: state_d = S_OUT;
      S_OUT: state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // multiplier issue
  always_comb begin
    mul_a  = MUL_W'(z_re_q);
    mul_b  = MUL_W'(z_re_q);
    mul_op = OP_NONE;
    case (state_q)
      S_MX: begin
        mul_a  = MUL_W'(z_re_q);
        mul_b  = $signed({{(MUL_W-13){1'b0}}, width_q});
        mul_op = OP_PX;
      end
      S_MY: begin
        mul_a  = MUL_W'(z_im_q);
        mul_b  = $signed({{(MUL_W-13){1'b0}}, height_q});
        mul_op = OP_PY;
      end
      S_SQI: begin
        mul_a  = MUL_W'(z_im_q);
        mul_b  = MUL_W'(z_im_q);
        mul_op = OP_SI;
      end
      S_SQR: begin
        mul_a  = MUL_W'(z_re_q);
        mul_b  = MUL_W'(z_re_q);
        mul_op = OP_SR;
      end
      S_CR: begin
        mul_a  = MUL_W'(z_im_q);
        mul_b  = MUL_W'(z_re_q);
        mul_op = OP_CR;
      end
      default: mul_op = OP_NONE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= 16'd255;
      power_q    <= 4'd1;
      width_q    <= 13'd640;
      height_q   <= 13'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_ITER: max_iter_q <= cfg_data_i;
        REG_POWER:    power_q    <= cfg_data_i[3:0];
        REG_WIDTH:    width_q    <= cfg_data_i[12:0];
        REG_HEIGHT:   height_q   <= cfg_data_i[12:0];
        default:      max_iter_q <= max_iter_q;
      endcase
    end
  end

  // orbit state and product write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_re_q    <= '0;
      z_im_q    <= '0;
      pt_re_q   <= '0;
      pt_im_q   <= '0;
      sq_re_q   <= '0;
      sq_im_q   <= '0;
      step_q    <= '0;
      running_q <= 1'b0;
      e_q       <= '0;
      px_q      <= '0;
      py_q      <= '0;
      res_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_q <= '0;
            if (in_data_i.start_req) begin
              pt_re_q   <= in_data_i.c_re;
              pt_im_q   <= in_data_i.c_im;
              z_re_q    <= in_data_i.c_re;
              z_im_q    <= in_data_i.c_im;
              sq_re_q   <= '0;
              sq_im_q   <= '0;
              step_q    <= '0;
              running_q <= 1'b1;
            end
          end
        end
        S_MY: e_q <= power_q;
        S_WB: e_q <= e_q - 4'd1;
        S_ESC: begin
          res_q.valid_res <= 1'b1;
          res_q.pixel_x   <= px_q;
          res_q.pixel_y   <= py_q;
          if (esc) begin
            res_q.last            <= 1'b1;
            res_q.escaped         <= 1'b1;
            res_q.iteration_count <= step_q;
            running_q             <= 1'b0;
          end else begin
            z_re_q        <= sat32(34'(z_re_q) + 34'(pt_re_q));
            z_im_q        <= sat32(34'(z_im_q) + 34'(pt_im_q));
            res_q.escaped <= 1'b0;
            if (step_q >= {1'b0, max_iter_q}) begin
              res_q.last            <= 1'b1;
              res_q.iteration_count <= {1'b0, max_iter_q} + 17'd1;
              running_q             <= 1'b0;
            end else begin
              res_q.last            <= 1'b0;
              res_q.iteration_count <= '0;
              step_q                <= step_q + 17'd1;
            end
          end
        end
        default: running_q <= running_q;
      endcase

      // products come back in the cycle after issue
      case (prod_op)
        OP_PX: px_q <= pix;
        OP_PY: py_q <= pix;
        OP_SI: sq_im_q <= qmul(prod);
        OP_SR: sq_re_q <= qmul(prod);
        OP_CR: begin
          z_re_q <= sat32(34'(sq_re_q) - 34'(sq_im_q));
          z_im_q <= sat32(34'(qmul(prod)) + 34'(qmul(prod)));
        end
        default: px_q <= px_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/mop_checker.sv
// port-level checks of the orbit plotter, bound to the top level
module mop_checker
  import mop_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // an accepted beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a beat");

  // a new result shows up just as the sequencer frees the input side
  a_rose_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while a step was still running");

  // escape only on the final point of an orbit
  a_escape_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.escaped |-> out_data_o.last && out_data_o.valid_res)
    else $error("escaped flag on a non-final point");

endmodule

bind multibrot_orbit_plotter mop_checker u_mop_checker (.*);
